// File: src/hgwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hgwm_pkg;

  // Fixed field and register widths
  localparam int unsigned OUT_W  = 11;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned ROW_W  = 6;

  // Frame bounds: minimum for rows and columns, maximum for rows
  localparam logic [CFG_W-1:0] MinDim  = 7'd3;
  localparam logic [CFG_W-1:0] RowsMax = 7'd64;

  // Register indexes on the configuration port
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GRID_COLS = 1'b0;
  localparam cfg_idx_t CFG_GRID_ROWS = 1'b1;

  // Reset value of both frame dimensions
  localparam logic [CFG_W-1:0] DIM_RESET = 7'd6;

endpackage

`default_nettype wire

// File: src/hourglass_window_max_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A frame's last accepted cell passes stage 1 and stage 2, then its result loads the output register.
// Throughput: one cell per cycle unless stalled; the line store is read at accept, written at s1_go.
// Input stalls only while a finished result waits unsent and the next frame's result is ready.
// Reset: asynchronous, active low; counters, window, running maximum and valids clear,
// dimensions return to 6x6. Line-store contents are not cleared.
module hourglass_window_max_unit #(
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned VALUE_BITS = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // cell input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [VALUE_BITS-1:0]       cell_value_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [hgwm_pkg::OUT_W-1:0]       max_sum_o,
  // configuration writes
  input  wire logic                               cfg_we_i,
  input  wire hgwm_pkg::cfg_idx_t                 cfg_idx_i,
  input  wire logic [hgwm_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import hgwm_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_COLS);
  localparam int unsigned CW    = ($clog2(MAX_COLS + 1) > CFG_W) ?
                                  $clog2(MAX_COLS + 1) : CFG_W;
  localparam int unsigned SUM_W = VALUE_BITS + 3;
  localparam int unsigned EXT_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;
  localparam int unsigned MEM_W = 2 * VALUE_BITS;
  localparam logic [CW-1:0] ColsMax = CW'(MAX_COLS);

  // configuration registers
  logic [CFG_W-1:0] grid_cols_q, grid_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= DIM_RESET;
      grid_rows_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_COLS: grid_cols_q <= cfg_wdata_i;
        CFG_GRID_ROWS: grid_rows_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // saturated frame size
  logic [CW-1:0]    cols, cols_m1, cols_raw;
  logic [CFG_W-1:0] rows, rows_m1;

  always_comb begin
    cols_raw = CW'(grid_cols_q);
    if (cols_raw < CW'(MinDim))    cols = CW'(MinDim);
    else if (cols_raw > ColsMax)   cols = ColsMax;
    else                           cols = cols_raw;
    cols_m1 = cols - CW'(1);
    if (grid_rows_q < MinDim)      rows = MinDim;
    else if (grid_rows_q > RowsMax) rows = RowsMax;
    else                           rows = grid_rows_q;
    rows_m1 = rows - CFG_W'(1);
  end

  // pipeline flow: only a frame-end beat in the last stage can block
  logic adv, in_acc, out_acc;
  logic s1_valid_q, s2_valid_q, s2_fe_q, out_valid_q;

  assign adv        = !(s2_valid_q && s2_fe_q && out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;
  assign out_acc    = out_valid_q && !out_stall_i;

  // stage 0: position counters and line-store read address
  logic [COL_W-1:0] col_q, col_d, c_eff;
  logic [ROW_W-1:0] row_q, row_d;
  logic             row_end, frame_end, win_ok;

  always_comb begin
    c_eff     = (CW'(col_q) >= cols) ? cols_m1[COL_W-1:0] : col_q;
    row_end   = (CW'(c_eff) >= cols_m1);
    frame_end = row_end && (CFG_W'(row_q) >= rows_m1);
    win_ok    = (row_q >= ROW_W'(2)) && (c_eff >= COL_W'(2));
    col_d     = col_q;
    row_d     = row_q;
    if (frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end else begin
      col_d = c_eff + COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1 beat registers
  logic signed [VALUE_BITS-1:0] s1_v_q;
  logic [COL_W-1:0]             s1_addr_q;
  logic                         s1_win_q, s1_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_v_q    <= cell_value_i;
      s1_addr_q <= c_eff;
      s1_win_q  <= win_ok;
      s1_fe_q   <= frame_end;
    end
  end

  // line stores: one memory, upper half is the row two up, lower half the row above
  logic [MEM_W-1:0] line_mem [MAX_COLS];
  logic [MEM_W-1:0] rdata_q;
  logic             s1_go;

  assign s1_go = s1_valid_q && adv;

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      line_mem[s1_addr_q] <= {rdata_q[VALUE_BITS-1:0], s1_v_q};
    end
    if (in_acc) begin
      rdata_q <= line_mem[c_eff];
    end
  end

  // stage 1: shift the 3x3 window and form the hourglass sum
  logic signed [VALUE_BITS-1:0] win_q [9];
  logic signed [VALUE_BITS-1:0] win_d [9];
  logic signed [VALUE_BITS-1:0] top, mid;
  logic signed [SUM_W-1:0]      sum;

  always_comb begin
    top = rdata_q[MEM_W-1:VALUE_BITS];
    mid = rdata_q[VALUE_BITS-1:0];
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]   = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = top;
    win_d[5] = mid;
    win_d[8] = s1_v_q;
    sum = SUM_W'(win_d[0]) + SUM_W'(win_d[1]) + SUM_W'(win_d[2]) + SUM_W'(win_d[4])
        + SUM_W'(win_d[6]) + SUM_W'(win_d[7]) + SUM_W'(win_d[8]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (s1_go) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

  // stage 2 beat registers
  logic signed [SUM_W-1:0] s2_sum_q;
  logic                    s2_win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_fe_q    <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
      s2_fe_q    <= s1_valid_q && s1_fe_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_sum_q <= sum;
      s2_win_q <= s1_win_q;
    end
  end

  // stage 2: running maximum and frame result
  logic signed [SUM_W-1:0] best_q, best_sel, res_sum;
  logic                    have_q, have_sel, s2_go, load;
  logic signed [EXT_W-1:0] res_ext;

  assign s2_go = s2_valid_q && adv;
  assign load  = s2_go && s2_fe_q;

  always_comb begin
    if (s2_win_q && (!have_q || (s2_sum_q > best_q))) best_sel = s2_sum_q;
    else                                              best_sel = best_q;
    have_sel = have_q || s2_win_q;
    res_sum  = have_sel ? best_sel : '0;
    res_ext  = EXT_W'(res_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      have_q <= 1'b0;
    end else if (s2_go) begin
      if (s2_fe_q) begin
        best_q <= '0;
        have_q <= 1'b0;
      end else begin
        best_q <= best_sel;
        have_q <= have_sel;
      end
    end
  end

  // output register
  logic signed [OUT_W-1:0] max_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load || (out_valid_q && !out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      max_sum_q <= res_ext[OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_sum_o   = max_sum_q;

endmodule

`default_nettype wire
